// ===== rtl/kummer_line_ladder_top_assert.svh =====
// Assertion macros for the Kummer-line ladder checker.
`ifndef KUMMER_LINE_LADDER_TOP_ASSERT_SVH
`define KUMMER_LINE_LADDER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define KLL_CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KLL_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kll_pkg.sv =====
// Package for the Kummer-line ladder: field constant, sequencer types and microprogram.
package kll_pkg;

    localparam int LADDER_BITS = 255;

    // p = 2^255 - 19
    localparam logic [255:0] P25519 = {1'b0, {250{1'b1}}, 5'b01101};

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MUL,
        ST_MDRAIN,
        ST_MTAIL,
        ST_FOLD1,
        ST_FOLD2,
        ST_FOLD3,
        ST_FOLD4,
        ST_RED1,
        ST_RED2,
        ST_WRITE,
        ST_COPY1,
        ST_COPY2,
        ST_COPY3,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_MULC
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] dst;
        logic [2:0] src_a;
        logic [2:0] src_b;
    } t_instr;

    // register file slots (AX/QX and AZ/QZ differ in bit 1 only)
    localparam logic [2:0] R_AX = 3'd0;
    localparam logic [2:0] R_AZ = 3'd1;
    localparam logic [2:0] R_QX = 3'd2;
    localparam logic [2:0] R_QZ = 3'd3;
    localparam logic [2:0] R_D  = 3'd4;
    localparam logic [2:0] R_B0 = 3'd5;
    localparam logic [2:0] R_B1 = 3'd6;

    // load sources
    localparam logic [2:0] L_PTX  = 3'd0;
    localparam logic [2:0] L_PTZ  = 3'd1;
    localparam logic [2:0] L_DIFF = 3'd2;
    localparam logic [2:0] L_C9F  = 3'd3;
    localparam logic [2:0] L_C05  = 3'd4;

    // small multiplier constants
    localparam logic [2:0] C_4D = 3'd0;
    localparam logic [2:0] C_52 = 3'd1;
    localparam logic [2:0] C_05 = 3'd2;
    localparam logic [2:0] C_9F = 3'd3;

    localparam logic [4:0] PC_INIT_END = 5'd4;
    localparam logic [4:0] PC_LOOP     = 5'd5;
    localparam logic [4:0] PC_LAST     = 5'd27;

    function automatic t_instr mk(input t_op op, input logic [2:0] d,
                                  input logic [2:0] a, input logic [2:0] b);
        t_instr r;
        r.op    = op;
        r.dst   = d;
        r.src_a = a;
        r.src_b = b;
        return r;
    endfunction

    function automatic t_instr kll_prog(input logic [4:0] pc);
        t_instr r;
        case (pc)
            5'd0:    r = mk(OP_LOAD, R_QX, L_PTX,  R_AX);
            5'd1:    r = mk(OP_LOAD, R_QZ, L_PTZ,  R_AX);
            5'd2:    r = mk(OP_LOAD, R_D,  L_DIFF, R_AX);
            5'd3:    r = mk(OP_LOAD, R_AX, L_C9F,  R_AX);
            5'd4:    r = mk(OP_LOAD, R_AZ, L_C05,  R_AX);
            5'd5:    r = mk(OP_ADD,  R_B0, R_AX, R_AZ);
            5'd6:    r = mk(OP_SUB,  R_B1, R_AX, R_AZ);
            5'd7:    r = mk(OP_ADD,  R_AX, R_QX, R_QZ);
            5'd8:    r = mk(OP_SUB,  R_AZ, R_QX, R_QZ);
            5'd9:    r = mk(OP_MUL,  R_QX, R_B0, R_B0);
            5'd10:   r = mk(OP_MUL,  R_QZ, R_B1, R_B1);
            5'd11:   r = mk(OP_MUL,  R_B0, R_B0, R_AX);
            5'd12:   r = mk(OP_MUL,  R_B1, R_B1, R_AZ);
            5'd13:   r = mk(OP_MULC, R_AX, R_QX, C_4D);
            5'd14:   r = mk(OP_MULC, R_AZ, R_QZ, C_52);
            5'd15:   r = mk(OP_MULC, R_B0, R_B0, C_4D);
            5'd16:   r = mk(OP_MULC, R_B1, R_B1, C_52);
            5'd17:   r = mk(OP_ADD,  R_QX, R_AX, R_AZ);
            5'd18:   r = mk(OP_SUB,  R_QZ, R_AX, R_AZ);
            5'd19:   r = mk(OP_ADD,  R_AX, R_B0, R_B1);
            5'd20:   r = mk(OP_SUB,  R_AZ, R_B0, R_B1);
            5'd21:   r = mk(OP_MUL,  R_B0, R_QX, R_QX);
            5'd22:   r = mk(OP_MUL,  R_B1, R_QZ, R_QZ);
            5'd23:   r = mk(OP_MUL,  R_QX, R_AX, R_AX);
            5'd24:   r = mk(OP_MUL,  R_QZ, R_AZ, R_AZ);
            5'd25:   r = mk(OP_MULC, R_AX, R_B0, C_05);
            5'd26:   r = mk(OP_MULC, R_AZ, R_B1, C_9F);
            5'd27:   r = mk(OP_MUL,  R_QZ, R_QZ, R_D);
            default: r = mk(OP_ADD,  R_B0, R_B0, R_B1);
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/kummer_line_ladder_top.sv =====
// Kummer-line Montgomery ladder mod 2^255-19 on one shared 32x32 multiplier.
// Usage:
//   Input channel (i_valid/o_stall): one request per 64-bit word, word_index 0..3,
//   carrying scalar, start X, start Z and affine x. A request with i_last set
//   starts the ladder; requests without it only store their word.
//   Output channel (o_valid/i_stall): four result requests, word 0 first, carrying
//   X:Z of n*P and (n+1)*P fully reduced; o_out_last marks word 3.
// Sequencing:
//   Each field operation is one microinstruction: add/sub run through read,
//   execute, reduce and write; a multiply feeds 64 partial products through the
//   single 32x32 multiplier, then folds and reduces. A ladder step is 8 add/sub
//   and 15 multiplies. o_stall is high for the whole ladder and result phase.
// Reset clears the sequencer; the word stores hold nothing until loaded.
// While i_stall is high the current result word is held unchanged.
module kummer_line_ladder_top import kll_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_word_index,
    input  logic [63:0] i_scalar_word,
    input  logic [63:0] i_start_x_word,
    input  logic [63:0] i_start_z_word,
    input  logic [63:0] i_diff_x_word,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_out_index,
    output logic [63:0] o_acc_x_word,
    output logic [63:0] o_acc_z_word,
    output logic [63:0] o_next_x_word,
    output logic [63:0] o_next_z_word,
    output logic        o_out_last
);

    t_state       r_state, n_state;
    logic [4:0]   r_pc, n_pc;
    logic [7:0]   r_cnt, n_cnt;
    logic         r_bit, n_bit;
    logic [1:0]   r_oidx, n_oidx;
    logic         r_pv;

    logic [255:0] r_scalar, r_ptx, r_ptz, r_diff;
    logic [255:0] r_fe [8];
    logic [255:0] r_rd_a, r_rd_b;
    logic [2:0]   rd_addr_a, rd_addr_b, wr_addr;
    logic         wr_en;
    t_instr       ins;

    logic [256:0] r_val;
    logic [256:0] red_t;
    logic [511:0] r_p;
    logic [262:0] r_fold;
    logic [71:0]  r_acc;
    logic [71:0]  acc_sum;
    logic [63:0]  r_prod;
    logic         r_pend;
    logic [3:0]   r_k, k_next;
    logic [2:0]   r_i, i_end, i_start, j_idx;
    logic         col_end, mul_last;
    logic [255:0] opb, const_val, load_val;
    logic [31:0]  a_limb, b_limb;
    logic [255:0] r_acc_x, r_acc_z, r_next_x, r_next_z;

    // ladder swap folded into slot renaming
    function automatic logic [2:0] phys(input logic [2:0] a, input logic s);
        return a[2] ? a : {1'b0, a[1] ^ s, a[0]};
    endfunction

    assign ins = kll_prog(r_pc);

    always_comb begin
        case (ins.src_b)
            C_4D:    const_val = 256'h4D;
            C_52:    const_val = 256'h52;
            C_05:    const_val = 256'h05;
            C_9F:    const_val = 256'h9F;
            default: const_val = '0;
        endcase
        case (ins.src_a)
            L_PTX:   load_val = r_ptx;
            L_PTZ:   load_val = r_ptz;
            L_DIFF:  load_val = r_diff;
            L_C9F:   load_val = 256'h9F;
            L_C05:   load_val = 256'h05;
            default: load_val = '0;
        endcase
    end

    assign opb      = (ins.op == OP_MULC) ? const_val : r_rd_b;
    assign j_idx    = 3'(r_k - {1'b0, r_i});
    assign a_limb   = r_rd_a[{r_i, 5'd0} +: 32];
    assign b_limb   = opb[{j_idx, 5'd0} +: 32];
    assign i_end    = r_k[3] ? 3'd7 : r_k[2:0];
    assign col_end  = (r_i == i_end);
    assign mul_last = col_end && (r_k == 4'd14);
    assign k_next   = r_k + 4'd1;
    assign i_start  = k_next[3] ? (k_next[2:0] + 3'd1) : 3'd0;
    assign acc_sum  = r_acc + {8'd0, r_prod};
    assign red_t    = r_val[256] ? (r_val + {1'b0, P25519}) : (r_val - {1'b0, P25519});

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_cnt     = r_cnt;
        n_bit     = r_bit;
        n_oidx    = r_oidx;
        wr_en     = 1'b0;
        wr_addr   = phys(ins.dst, r_bit);
        rd_addr_a = phys(ins.src_a, r_bit);
        rd_addr_b = phys(ins.src_b, r_bit);
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_last) begin
                    n_state = ST_READ;
                    n_pc    = '0;
                end
            end
            ST_READ:   n_state = ST_EXEC;
            ST_EXEC: begin
                if (ins.op == OP_MUL || ins.op == OP_MULC) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_RED1;
                end
            end
            ST_MUL: begin
                if (mul_last) begin
                    n_state = ST_MDRAIN;
                end
            end
            ST_MDRAIN: n_state = ST_MTAIL;
            ST_MTAIL:  n_state = ST_FOLD1;
            ST_FOLD1:  n_state = ST_FOLD2;
            ST_FOLD2:  n_state = ST_FOLD3;
            ST_FOLD3:  n_state = ST_FOLD4;
            ST_FOLD4:  n_state = ST_RED1;
            ST_RED1:   n_state = ST_RED2;
            ST_RED2:   n_state = ST_WRITE;
            ST_WRITE: begin
                wr_en = 1'b1;
                if (r_pc == PC_LAST) begin
                    if (r_cnt == '0) begin
                        n_bit   = 1'b0;
                        n_state = ST_COPY1;
                    end else begin
                        n_cnt   = r_cnt - 8'd1;
                        n_bit   = r_scalar[r_cnt - 8'd1];
                        n_pc    = PC_LOOP;
                        n_state = ST_READ;
                    end
                end else if (r_pc == PC_INIT_END) begin
                    n_cnt   = 8'(LADDER_BITS - 1);
                    n_bit   = r_scalar[8'(LADDER_BITS - 1)];
                    n_pc    = r_pc + 5'd1;
                    n_state = ST_READ;
                end else begin
                    n_pc    = r_pc + 5'd1;
                    n_state = ST_READ;
                end
            end
            ST_COPY1: begin
                rd_addr_a = R_AX;
                rd_addr_b = R_AZ;
                n_state   = ST_COPY2;
            end
            ST_COPY2: begin
                rd_addr_a = R_QX;
                rd_addr_b = R_QZ;
                n_state   = ST_COPY3;
            end
            ST_COPY3: begin
                n_oidx  = '0;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_oidx = r_oidx + 2'd1;
                    if (r_oidx == 2'd3) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_cnt   <= '0;
            r_bit   <= 1'b0;
            r_oidx  <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
            r_bit   <= n_bit;
            r_oidx  <= n_oidx;
            r_pv    <= (r_state == ST_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_fe[rd_addr_a];
        r_rd_b <= r_fe[rd_addr_b];
        if (wr_en) begin
            r_fe[wr_addr] <= r_val[255:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_scalar[{i_word_index, 6'd0} +: 64] <= i_scalar_word;
            r_ptx[{i_word_index, 6'd0} +: 64]    <= i_start_x_word;
            r_ptz[{i_word_index, 6'd0} +: 64]    <= i_start_z_word;
            r_diff[{i_word_index, 6'd0} +: 64]   <= i_diff_x_word;
        end

        // multiply then column accumulate
        r_prod <= a_limb * b_limb;
        r_pend <= col_end;
        if (r_pv) begin
            if (r_pend) begin
                r_p   <= {acc_sum[31:0], r_p[511:32]};
                r_acc <= {32'd0, acc_sum[71:32]};
            end else begin
                r_acc <= acc_sum;
            end
        end

        case (r_state)
            ST_EXEC: begin
                case (ins.op)
                    OP_LOAD: r_val <= {1'b0, load_val};
                    OP_ADD:  r_val <= {1'b0, r_rd_a} + {1'b0, r_rd_b};
                    OP_SUB:  r_val <= {1'b0, r_rd_a} - {1'b0, r_rd_b};
                    default: begin
                        r_k   <= '0;
                        r_i   <= '0;
                        r_acc <= '0;
                    end
                endcase
            end
            ST_MUL: begin
                if (col_end) begin
                    r_k <= k_next;
                    r_i <= i_start;
                end else begin
                    r_i <= r_i + 3'd1;
                end
            end
            ST_MTAIL: r_p <= {r_acc[31:0], r_p[511:32]};
            ST_FOLD1: begin
                // 2^256 = 38 mod p
                r_fold <= ({7'd0, r_p[511:256]} << 5) + ({7'd0, r_p[511:256]} << 2)
                        + ({7'd0, r_p[511:256]} << 1);
            end
            ST_FOLD2: r_fold <= {7'd0, r_p[255:0]} + r_fold;
            ST_FOLD3: begin
                r_fold <= {7'd0, r_fold[255:0]}
                        + {250'd0, {6'd0, r_fold[262:256]} * 13'd38};
            end
            ST_FOLD4: begin
                r_val <= {1'b0, r_fold[255:0]
                        + {243'd0, {6'd0, r_fold[262:256]} * 13'd38}};
            end
            ST_RED1, ST_RED2: begin
                if (r_val[256]) begin
                    r_val <= {1'b0, red_t[255:0]};
                end else if (!red_t[256]) begin
                    r_val <= red_t;
                end
            end
            ST_COPY2: begin
                r_acc_x <= r_rd_a;
                r_acc_z <= r_rd_b;
            end
            ST_COPY3: begin
                r_next_x <= r_rd_a;
                r_next_z <= r_rd_b;
            end
            default: ;
        endcase
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = (r_state == ST_OUT);
    assign o_out_index   = r_oidx;
    assign o_out_last    = (r_oidx == 2'd3);
    assign o_acc_x_word  = r_acc_x[{r_oidx, 6'd0} +: 64];
    assign o_acc_z_word  = r_acc_z[{r_oidx, 6'd0} +: 64];
    assign o_next_x_word = r_next_x[{r_oidx, 6'd0} +: 64];
    assign o_next_z_word = r_next_z[{r_oidx, 6'd0} +: 64];

endmodule

// ===== rtl/kll_checker.sv =====
// Port-level checker for the Kummer-line ladder, bound to the top level.
`include "kummer_line_ladder_top_assert.svh"

module kll_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_out_index,
    input logic        o_out_last
);

    `KLL_CHK_SAME(a_busy_while_out, o_valid, o_stall, "input taken while results pending")
    `KLL_CHK_NEXT(a_hold_on_stall, o_valid && i_stall, o_valid && $stable(o_out_index), "result dropped under stall")
    `KLL_CHK_NEXT(a_end_after_last, o_valid && !i_stall && o_out_last, !o_valid, "extra result after last word")
    `KLL_CHK_NEXT(a_index_steps, o_valid && !i_stall && !o_out_last, o_valid && (o_out_index == $past(o_out_index) + 2'd1), "result word skipped")

endmodule

bind kummer_line_ladder_top kll_checker u_kll_checker (.*);
